// ===== hdl/retry_backoff_jitter_scheduler_assert.svh =====
// Assertion macros for the retry backoff scheduler.
// RBJ_ASSERT: clocked, disabled while reset is asserted.
// RBJ_ASSERT_ALWAYS: clocked, checked during reset too.
`ifndef RETRY_BACKOFF_JITTER_SCHEDULER_ASSERT_SVH
`define RETRY_BACKOFF_JITTER_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

`define RBJ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define RBJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RBJ_ASSERT(lbl, clk, rst_n, prop, msg)

`define RBJ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/rbj_pkg.sv =====
package rbj_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int MIN_DELAY_RANGE   = 256;
  localparam int MS_PER_SECOND     = 1000;
  localparam int HALF_MS           = MS_PER_SECOND / 2;
  localparam int QUEUE_DEPTH       = 2;

  localparam int TABLE_W   = 64;
  localparam int TIMEOUT_W = 16;
  localparam int RND_W     = 32;
  localparam int DELAY_W   = 26;
  localparam int ADV_W     = 2;
  localparam int CNT_W     = 4;
  // divisor covers 65535*500 and MIN_DELAY_RANGE up to 65536
  localparam int DIV_W     = 25;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = TABLE_W;

  localparam logic [TABLE_W-1:0]   TABLE_RESET   = 64'd516740879370;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TABLE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TIMEOUT = 1'd1;

  localparam logic OP_INC = 1'b0;
  localparam logic OP_RST = 1'b1;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_s;
    logic [DIV_W-1:0]     base;
    logic [DIV_W-1:0]     divisor;
    logic [RND_W-1:0]     rnd;
    logic [ADV_W-1:0]     adv;
    logic                 fallback;
    logic [CNT_W-1:0]     attempt;
  } job_t;

endpackage

// ===== hdl/rbj_if.sv =====
interface rbj_in_if;
  import rbj_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [RND_W-1:0] random_value;

  modport source (output valid, op, random_value, input ready);
  modport sink (input valid, op, random_value, output ready);
endinterface

interface rbj_out_if;
  import rbj_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] timeout_s;
  logic [DELAY_W-1:0]   delay_ms;
  logic [ADV_W-1:0]     endpoint_advances;
  logic                 used_fallback;
  logic [CNT_W-1:0]     attempt;

  modport source (output valid, timeout_s, delay_ms, endpoint_advances, used_fallback,
                  attempt, input ready);
  modport sink (input valid, timeout_s, delay_ms, endpoint_advances, used_fallback,
                attempt, output ready);
endinterface

// ===== hdl/rbj_queue.sv =====
module rbj_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  rbj_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rbj_pkg::job_t pop_job
);
  import rbj_pkg::*;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t               slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [COUNT_W-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != COUNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) count_r <= count_r + COUNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

// ===== hdl/rbj_front.sv =====
module rbj_front #(
  parameter int TABLE_ENTRIES = rbj_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rbj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbj_pkg::CFG_DATA_W-1:0] cfg_data,
  rbj_in_if.sink                         in_ch,
  output logic                           push_valid,
  input  logic                           push_ready,
  output rbj_pkg::job_t                  push_job
);
  import rbj_pkg::*;

  localparam int STORE_W = 8 * TABLE_ENTRIES;

  logic [STORE_W-1:0]   table_r;
  logic [TIMEOUT_W-1:0] reset_timeout_r;
  logic [CNT_W-1:0]     count_r;

  logic [CNT_W-1:0]     cnt_inc;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [CNT_W-1:0]     size;
  logic                 size_done;
  logic                 ok;
  logic [ADV_W-1:0]     adv;
  logic                 fallback;
  logic [TIMEOUT_W-1:0] tmo;
  logic [DIV_W-1:0]     half_ms;

  // table size: leading nonzero bytes
  always_comb begin
    size      = '0;
    size_done = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!size_done && (table_r[8*i +: 8] != 8'd0)) size = size + CNT_W'(1);
      else size_done = 1'b1;
    end
  end

  always_comb begin
    cnt_inc  = (in_ch.op == OP_INC) ? count_r + CNT_W'(1) : '0;
    cnt_nxt  = cnt_inc;
    adv      = '0;
    fallback = 1'b0;
    ok       = (cnt_inc < size);
    // end of table: advance endpoint and restart at entry 0
    if (!ok) begin
      adv = ADV_W'(1);
      if (cnt_inc != '0) begin
        cnt_nxt = '0;
        ok      = (size != '0);
        if (!ok) adv = ADV_W'(2);
      end
    end
    tmo = reset_timeout_r;
    if (ok) begin
      tmo = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (cnt_nxt == CNT_W'(i)) tmo = {8'd0, table_r[8*i +: 8]};
      end
    end else begin
      fallback = 1'b1;
    end
  end

  assign half_ms = {{(DIV_W-TIMEOUT_W){1'b0}}, tmo} * DIV_W'(HALF_MS);

  always_comb begin
    push_job.timeout_s = tmo;
    push_job.base      = (tmo == '0) ? '0 : half_ms;
    push_job.divisor   = (tmo == '0) ? DIV_W'(MIN_DELAY_RANGE) : half_ms;
    push_job.rnd       = in_ch.random_value;
    push_job.adv       = adv;
    push_job.fallback  = fallback;
    push_job.attempt   = cnt_nxt;
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r         <= '0;
      table_r         <= TABLE_RESET[STORE_W-1:0];
      reset_timeout_r <= TIMEOUT_RESET;
    end else begin
      if (in_ch.valid && push_ready) count_r <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RETRY_TABLE:   table_r <= cfg_data[STORE_W-1:0];
          CFG_RESET_TIMEOUT: reset_timeout_r <= cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/rbj_back.sv =====
`include "retry_backoff_jitter_scheduler_assert.svh"

module rbj_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  rbj_pkg::job_t pop_job,
  rbj_out_if.source     out_ch
);
  import rbj_pkg::*;

  localparam int STEP_W = $clog2(RND_W);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state_r;
  logic [STEP_W-1:0]    step_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     rem_nxt;
  logic [DIV_W:0]       rem_sh;
  job_t                 job_r;

  logic                 out_valid_r;
  logic [TIMEOUT_W-1:0] out_timeout_r;
  logic [DELAY_W-1:0]   out_delay_r;
  logic [ADV_W-1:0]     out_adv_r;
  logic                 out_fb_r;
  logic [CNT_W-1:0]     out_attempt_r;

  assign pop_ready = (state_r == ST_IDLE) && !out_valid_r;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    rem_sh = {rem_r, job_r.rnd[RND_W-1]};
    if (rem_sh >= {1'b0, job_r.divisor}) rem_nxt = DIV_W'(rem_sh - {1'b0, job_r.divisor});
    else rem_nxt = rem_sh[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (pop_valid && pop_ready) begin
            state_r <= ST_RUN;
            step_r  <= '0;
          end
        end
        ST_RUN: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(RND_W - 1)) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      if (pop_valid && pop_ready) begin
        job_r <= pop_job;
        rem_r <= '0;
      end
    end else begin
      rem_r     <= rem_nxt;
      job_r.rnd <= {job_r.rnd[RND_W-2:0], 1'b0};
      if (step_r == STEP_W'(RND_W - 1)) begin
        out_timeout_r <= job_r.timeout_s;
        out_delay_r   <= DELAY_W'(job_r.base) + DELAY_W'(rem_nxt);
        out_adv_r     <= job_r.adv;
        out_fb_r      <= job_r.fallback;
        out_attempt_r <= job_r.attempt;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.timeout_s         = out_timeout_r;
  assign out_ch.delay_ms          = out_delay_r;
  assign out_ch.endpoint_advances = out_adv_r;
  assign out_ch.used_fallback     = out_fb_r;
  assign out_ch.attempt           = out_attempt_r;

  `RBJ_ASSERT(a_rem_below_div, clk, rst_n, (state_r == ST_RUN) |-> (rem_r < job_r.divisor), "remainder not below divisor")
  `RBJ_ASSERT(a_pop_starts_run, clk, rst_n, (pop_valid && pop_ready) |=> (state_r == ST_RUN && step_r == '0), "pop did not start a division")
  `RBJ_ASSERT(a_result_from_run, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_RUN), "result raised outside a division")
  `RBJ_ASSERT(a_no_pop_while_busy, clk, rst_n, (state_r == ST_RUN || out_valid_r) |-> !pop_ready, "pop offered while busy")

endmodule

// ===== hdl/retry_backoff_jitter_scheduler.sv =====
// Channel  Dir  Payload                                                   Accept
// in_ch    in   op, random_value                                          valid && ready
// out_ch   out  timeout_s, delay_ms, endpoint_advances, used_fallback,    valid && ready
//               attempt
// cfg      in   cfg_index, cfg_data                                       cfg_we
//
// An item is classified in its accept cycle and queued (two entries).
// The back end pops one item, runs a 32-step bit-serial remainder of
// random_value by the delay range, and registers the result; it takes no new
// item until that result has been taken on out_ch. The front keeps accepting
// while the queue has room, also while a result waits on out_ch. Reset clears
// the retry count and loads the register defaults; no clearing pass.
module retry_backoff_jitter_scheduler #(
  parameter int TABLE_ENTRIES = rbj_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rbj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbj_pkg::CFG_DATA_W-1:0] cfg_data,
  rbj_in_if.sink                         in_ch,
  rbj_out_if.source                      out_ch
);
  import rbj_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  rbj_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  rbj_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  rbj_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule
